// File: sv/drfr_pkg.sv
package drfr_pkg;

	// frame store geometry and frame limit
	localparam int BUF_DEPTH = 128;
	localparam int MAX_FRAME = 80;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = ($clog2(BUF_DEPTH + 1) > 8) ? $clog2(BUF_DEPTH + 1) : 8;
	localparam int PL_W      = CNT_W + 2;

	// special bytes on the reply link
	localparam logic [7:0] BYTE_NUL         = 8'h00;
	localparam logic [7:0] BYTE_ANS_OPEN    = 8'hA4;
	localparam logic [7:0] BYTE_ANS_CLOSE   = 8'hA7;
	localparam logic [7:0] BYTE_TERM        = 8'hFF;
	localparam logic [7:0] BYTE_BLOCK_DONE  = 8'hFD;
	localparam logic [7:0] BYTE_BLOCK_READY = 8'hFE;
	localparam logic [7:0] BYTE_ERROR       = 8'h1A;
	localparam logic [7:0] BYTE_TEXT        = 8'h70;
	localparam logic [7:0] BYTE_CONNECT     = 8'h63;

	// item opcodes
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// configuration register indexes
	localparam logic REG_RAW = 1'b0;
	localparam logic REG_CAP = 1'b1;

	// reply codes
	localparam logic [2:0] REPLY_NONE        = 3'd0;
	localparam logic [2:0] REPLY_BLOCK_DONE  = 3'd1;
	localparam logic [2:0] REPLY_BLOCK_READY = 3'd2;
	localparam logic [2:0] REPLY_ERROR       = 3'd3;
	localparam logic [2:0] REPLY_TEXT        = 3'd4;
	localparam logic [2:0] REPLY_CONNECT     = 3'd5;

	// answer tracking phases
	localparam logic [1:0] ANS_NONE   = 2'd0;
	localparam logic [1:0] ANS_OPEN   = 2'd1;
	localparam logic [1:0] ANS_CLOSED = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RECV = 2'd1,
		MODE_DONE = 2'd2
	} rx_mode_t;

	// frame store access for one cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// status after one item, as handed to the output stage
	typedef struct packed {
		rx_mode_t         mode;
		logic [CNT_W-1:0] count;
		logic [2:0]       reply;
		logic             done;
		logic [1:0]       answer;
		logic             str_cmp;
		logic [6:0]       pay_len;
		logic             rd_sel;
		logic             rd_first;
		logic [7:0]       first;
	} result_t;

endpackage

// File: sv/drfr_store.sv
module drfr_store (
	input  logic               clk,
	input  drfr_pkg::mem_req_t req,
	output logic [7:0]         rdata
);

	logic [7:0] mem [drfr_pkg::BUF_DEPTH];
	logic [7:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/drfr_ctrl.sv
module drfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [1:0]          opcode,
	input  logic [7:0]          byte_value,
	input  logic [6:0]          read_index,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_wdata,
	output drfr_pkg::mem_req_t  mem_req,
	output drfr_pkg::result_t   res_n,
	output logic                busy
);

	localparam int CNT_W  = drfr_pkg::CNT_W;
	localparam int ADDR_W = drfr_pkg::ADDR_W;
	localparam int PL_W   = drfr_pkg::PL_W;

	drfr_pkg::rx_mode_t mode_q, mode_n;
	logic [CNT_W-1:0]   fill_q, fill_n;
	logic [1:0]         ff_q, ff_n;
	logic [7:0]         last_q, last_n;
	logic [2:0]         class_q, class_n;
	logic               done_q, done_n;
	logic [1:0]         ans_q, ans_n;
	logic [7:0]         first_q, first_n;
	logic               raw_q;
	logic [7:0]         cap_q;
	logic               nul_pend_q, nul_pend_n;
	logic [ADDR_W-1:0]  nul_addr_q;

	logic               do_byte, do_rst, do_rd, parse, append;
	logic               has_room, close_hit, overlong, rd_in_range;
	logic               is_term, is_ans_close;
	logic [CNT_W-1:0]   base_fill, app_fill;
	logic [1:0]         ff_inc;
	logic signed [PL_W-1:0] pl_cnt, pl_cap, pl_val;

	function automatic logic [2:0] classify(input logic [7:0] first, input logic [2:0] prev);
		logic [2:0] code;
		case (first)
			drfr_pkg::BYTE_BLOCK_DONE:  code = drfr_pkg::REPLY_BLOCK_DONE;
			drfr_pkg::BYTE_BLOCK_READY: code = drfr_pkg::REPLY_BLOCK_READY;
			drfr_pkg::BYTE_ERROR:       code = drfr_pkg::REPLY_ERROR;
			drfr_pkg::BYTE_TEXT:        code = drfr_pkg::REPLY_TEXT;
			drfr_pkg::BYTE_CONNECT:     code = drfr_pkg::REPLY_CONNECT;
			default:                    code = prev;
		endcase
		return code;
	endfunction

	// item decode and append position
	always_comb begin
		do_byte      = take && (opcode == drfr_pkg::OP_BYTE);
		do_rst       = take && (opcode == drfr_pkg::OP_RESTART);
		do_rd        = take && (opcode == drfr_pkg::OP_READ);
		parse        = do_byte && !raw_q;
		is_term      = (byte_value == drfr_pkg::BYTE_TERM);
		is_ans_close = (byte_value == drfr_pkg::BYTE_ANS_CLOSE);
		base_fill    = (parse && (mode_q == drfr_pkg::MODE_IDLE)) ? '0 : fill_q;
		has_room     = 32'(base_fill) < drfr_pkg::BUF_DEPTH;
		app_fill     = has_room ? base_fill + CNT_W'(1) : base_fill;
		ff_inc       = (ff_q == 2'd3) ? 2'd3 : ff_q + 2'd1;
		append       = do_byte && (raw_q || (mode_q == drfr_pkg::MODE_RECV) ||
			((mode_q == drfr_pkg::MODE_IDLE) && (byte_value != drfr_pkg::BYTE_NUL)));
		close_hit    = parse && (mode_q == drfr_pkg::MODE_RECV) && is_term &&
			(32'(app_fill) > 3) && (ff_inc == 2'd3);
		overlong     = parse && (mode_q == drfr_pkg::MODE_RECV) && !is_term &&
			!is_ans_close && (32'(app_fill) > drfr_pkg::MAX_FRAME);
		rd_in_range  = 32'(read_index) < drfr_pkg::BUF_DEPTH;
	end

	// receive mode next state
	always_comb begin
		mode_n = mode_q;
		if (do_rst) begin
			mode_n = drfr_pkg::MODE_IDLE;
		end else if (parse) begin
			case (mode_q)
				drfr_pkg::MODE_IDLE: begin
					if (byte_value != drfr_pkg::BYTE_NUL) begin
						mode_n = drfr_pkg::MODE_RECV;
					end
				end
				drfr_pkg::MODE_RECV: begin
					if (close_hit) begin
						mode_n = drfr_pkg::MODE_DONE;
					end else if (overlong) begin
						mode_n = drfr_pkg::MODE_IDLE;
					end
				end
				default: mode_n = mode_q;
			endcase
		end
	end

	// frame bookkeeping next values
	always_comb begin
		fill_n     = fill_q;
		ff_n       = ff_q;
		last_n     = last_q;
		class_n    = class_q;
		done_n     = done_q;
		ans_n      = ans_q;
		first_n    = first_q;
		nul_pend_n = 1'b0;
		if (do_rst) begin
			fill_n  = '0;
			ff_n    = 2'd0;
			last_n  = drfr_pkg::BYTE_NUL;
			class_n = drfr_pkg::REPLY_NONE;
			done_n  = 1'b0;
			ans_n   = drfr_pkg::ANS_NONE;
			first_n = drfr_pkg::BYTE_NUL;
		end else begin
			if (append) begin
				fill_n = app_fill;
				if (has_room) begin
					last_n = byte_value;
					if (base_fill == '0) begin
						first_n = byte_value;
					end
				end
			end
			if (parse && (mode_q == drfr_pkg::MODE_IDLE) &&
				(byte_value != drfr_pkg::BYTE_NUL)) begin
				ff_n = is_term ? 2'd1 : 2'd0;
				if (byte_value == drfr_pkg::BYTE_ANS_OPEN) begin
					ans_n = drfr_pkg::ANS_OPEN;
				end
			end
			if (parse && (mode_q == drfr_pkg::MODE_RECV)) begin
				if (is_ans_close) begin
					ff_n = 2'd0;
					if (ans_q == drfr_pkg::ANS_OPEN) begin
						ans_n = drfr_pkg::ANS_CLOSED;
					end
				end else if (is_term) begin
					ff_n = ff_inc;
				end else begin
					ff_n = 2'd0;
				end
			end
			if (overlong) begin
				fill_n = '0;
			end
			if (close_hit) begin
				done_n     = 1'b1;
				class_n    = classify(first_n, class_q);
				nul_pend_n = 32'(app_fill) < drfr_pkg::BUF_DEPTH;
			end
		end
	end

	// payload length from count and caller capacity
	always_comb begin
		pl_cnt = PL_W'(fill_n);
		pl_cap = PL_W'(cap_q);
		pl_val = (pl_cnt < pl_cap + PL_W'(2)) ? pl_cnt - PL_W'(2) : pl_cap - PL_W'(1);
		if (pl_val < 0) begin
			pl_val = '0;
		end else if (pl_val > PL_W'(127)) begin
			pl_val = PL_W'(127);
		end
	end

	// store access: the terminating nul takes the port in its own cycle
	always_comb begin
		mem_req.re    = do_rd && rd_in_range;
		mem_req.raddr = ADDR_W'(read_index);
		if (nul_pend_q) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = nul_addr_q;
			mem_req.wdata = drfr_pkg::BYTE_NUL;
		end else begin
			mem_req.we    = append && has_room;
			mem_req.waddr = base_fill[ADDR_W-1:0];
			mem_req.wdata = byte_value;
		end
	end

	// status after this item
	always_comb begin
		res_n.mode     = mode_n;
		res_n.count    = fill_n;
		res_n.reply    = class_n;
		res_n.done     = done_n;
		res_n.answer   = ans_n;
		res_n.str_cmp  = (32'(fill_n) > 1) && (first_n == drfr_pkg::BYTE_ANS_OPEN) &&
			(last_n == drfr_pkg::BYTE_ANS_CLOSE);
		res_n.pay_len  = pl_val[6:0];
		res_n.rd_sel   = do_rd && rd_in_range;
		res_n.rd_first = (read_index == 7'd0);
		res_n.first    = first_n;
	end

	assign busy = nul_pend_q;

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= drfr_pkg::MODE_IDLE;
			fill_q     <= '0;
			ff_q       <= 2'd0;
			last_q     <= drfr_pkg::BYTE_NUL;
			class_q    <= drfr_pkg::REPLY_NONE;
			done_q     <= 1'b0;
			ans_q      <= drfr_pkg::ANS_NONE;
			first_q    <= drfr_pkg::BYTE_NUL;
			nul_pend_q <= 1'b0;
			nul_addr_q <= '0;
		end else begin
			mode_q     <= mode_n;
			fill_q     <= fill_n;
			ff_q       <= ff_n;
			last_q     <= last_n;
			class_q    <= class_n;
			done_q     <= done_n;
			ans_q      <= ans_n;
			first_q    <= first_n;
			nul_pend_q <= nul_pend_n;
			if (nul_pend_n) begin
				nul_addr_q <= app_fill[ADDR_W-1:0];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
			cap_q <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				drfr_pkg::REG_RAW: raw_q <= cfg_wdata[0];
				drfr_pkg::REG_CAP: cap_q <= cfg_wdata;
				default: raw_q <= raw_q;
			endcase
		end
	end

endmodule

// File: sv/display_reply_frame_receiver.sv
// Reply frame receiver for a serial display link. Each input transfer carries one
// opcode: a received byte, a restart, or a read of one frame store entry; each
// produces exactly one status transfer on the output side. Items are taken one per
// cycle unless the output stalls, with one exception: the transfer that closes a frame
// with three 0xFF bytes is followed by a single cycle with s_tready low, while the one
// write port of the frame store writes the terminating NUL; when the store is full the
// NUL is dropped and no such cycle follows. The store is a 128 x 8 synchronous memory
// with no clearing pass after reset; entry zero is shadowed in a register, so it reads
// as zero after reset and after a restart. Other entries read back whatever they
// last held, so they should be read only after they have been written.
module display_reply_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], byte_value[9:2], read_index[16:10], zero[23:17]
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// rx_state[1:0], byte_count[9:2], reply_code[12:10], frame_done[13],
	// answer_phase[15:14], string_complete[16], read_data[24:17], payload_length[31:25]
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	drfr_pkg::mem_req_t mem_req;
	drfr_pkg::result_t  res_n;
	drfr_pkg::result_t  out_s1;
	logic               out_valid_q;
	logic               busy;
	logic               take;
	logic [7:0]         mem_rdata;
	logic [7:0]         read_data;
	logic [7:0]         byte_count;

	// input transfer when the output slot frees up and the store port is free
	assign s_tready = (!out_valid_q || m_tready) && !busy;
	assign take     = s_tvalid && s_tready;

	drfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.opcode     (s_tdata[1:0]),
		.byte_value (s_tdata[9:2]),
		.read_index (s_tdata[16:10]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mem_req    (mem_req),
		.res_n      (res_n),
		.busy       (busy)
	);

	drfr_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_s1 <= res_n;
		end
	end

	// read data: entry zero from its shadow, others from the store
	always_comb begin
		if (!out_s1.rd_sel) begin
			read_data = 8'd0;
		end else if (out_s1.rd_first) begin
			read_data = out_s1.first;
		end else begin
			read_data = mem_rdata;
		end
		byte_count = (32'(out_s1.count) > 255) ? 8'hFF : out_s1.count[7:0];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_s1.pay_len, read_data, out_s1.str_cmp, out_s1.answer,
		out_s1.done, out_s1.reply, byte_count, out_s1.mode};

endmodule
